/* rtl/core/sparse_column_matvec_accumulate_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sparse column mat-vec accumulate unit: assertion macros
// Short forms for the concurrent checks of the unit's checker.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_MATVEC_ACCUMULATE_UNIT_MACROS_SVH
`define SPARSE_COLUMN_MATVEC_ACCUMULATE_UNIT_MACROS_SVH

// Check on every rising edge of clk_i, off while rst_ni is low.
`define SCMVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define SCMVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/scmva_pkg.sv */
// ----------------------------------------------------------------------------
// scmva_pkg
// Shared constants, command codes and stage control type of the sparse
// column mat-vec accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scmva_pkg;

  localparam int unsigned ROWS_DEF       = 256;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned ROW_BITS       = 8;
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned ACC_BITS       = 48;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ENTRY = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic valid;
    logic entry;
    logic read;
    logic in_range;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/scmva_if.sv */
// ----------------------------------------------------------------------------
// scmva_if
// Command and result channels of the sparse column mat-vec accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface scmva_in_if import scmva_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [ROW_BITS-1:0]          row_index;
  logic signed [FIELD_BITS-1:0] matrix_value;
  logic signed [FIELD_BITS-1:0] vector_value;

  modport source (
    output valid, cmd, row_index, matrix_value, vector_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, row_index, matrix_value, vector_value,
    output ready
  );
endinterface

interface scmva_out_if import scmva_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ACC_BITS-1:0] row_sum;
  logic                       overflowed;

  modport source (
    output valid, row_sum, overflowed,
    input  ready
  );
  modport sink (
    input  valid, row_sum, overflowed,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/sparse_column_matvec_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// sparse_column_matvec_accumulate_unit
// Sparse matrix times dense vector in column order, 48-bit saturating row
// accumulators held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel | dir | words carried
//  --------+-----+----------------------------------------------------------
//  in_i    | in  | cmd, row_index, matrix_value, vector_value
//  out_o   | out | row_sum, overflowed (one word per read command)
//
//  One command per cycle. Stage 0 multiplies and reads the row; stage 1
//  adds, saturates and writes back, forwarding to a following command on
//  the same row. A read command is registered into stage 1 and its result into the output register.
//  Reset clears the column value, the output valid bit and the row valid
//  bits at once; no clearing pass is needed.
//  in_i.ready drops only while a read waits in stage 1 behind a full
//  output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_column_matvec_accumulate_unit import scmva_pkg::*; #(
  parameter int unsigned ROWS       = ROWS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  scmva_in_if.sink    in_i,
  scmva_out_if.source out_o
);

  localparam int unsigned MaxRows = 2 ** ROW_BITS;
  localparam int unsigned Depth   = (ROWS < MaxRows) ? ROWS : MaxRows;
  localparam int unsigned AW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OPW     = (VALUE_BITS <= FIELD_BITS) ? VALUE_BITS : FIELD_BITS + 1;
  localparam int unsigned PW      = 2 * OPW;
  localparam int unsigned MW      = ACC_BITS + 1;

  // low VALUE_BITS of a field, sign extended; wider settings see it unsigned
  function automatic logic signed [OPW-1:0] to_op(input logic [FIELD_BITS-1:0] f);
    logic [FIELD_BITS:0] fx;
    fx = {1'b0, f};
    return $signed(fx[OPW-1:0]);
  endfunction

  logic                       accept;
  logic                       stall;
  logic                       in_range;
  logic [AW-1:0]              in_addr;
  logic signed [OPW-1:0]      col_q;
  logic signed [OPW-1:0]      mat_op;
  logic signed [PW-1:0]       prod_d, prod_q;
  stage_ctl_t                 ctl_d, ctl_q;
  logic [AW-1:0]              addr_q;
  logic [MW-1:0]              mem_rd;
  logic                       fwd_hit_q;
  logic [MW-1:0]              fwd_data_q;
  logic [MW-1:0]              row_word;
  logic                       wr_en_raw, wr_en;
  logic signed [ACC_BITS-1:0] wr_acc, res_sum;
  logic                       wr_sat, res_ovf;
  logic                       out_valid_q;
  logic signed [ACC_BITS-1:0] out_sum_q;
  logic                       out_ovf_q;
  logic                       out_load;

  assign stall      = ctl_q.valid && ctl_q.read && out_valid_q;
  assign in_i.ready = !stall;
  assign accept     = in_i.valid && in_i.ready;

  assign in_range = {1'b0, in_i.row_index} < (ROW_BITS + 1)'(Depth);
  assign in_addr  = in_i.row_index[AW-1:0];
  assign mat_op   = to_op(in_i.matrix_value);
  assign prod_d   = mat_op * col_q;

  always_comb begin
    ctl_d.entry    = in_i.cmd == CMD_ENTRY;
    ctl_d.read     = in_i.cmd == CMD_READ;
    ctl_d.in_range = in_range;
    ctl_d.valid    = accept && (ctl_d.entry || ctl_d.read);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      ctl_q     <= '0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (accept && in_i.cmd == CMD_START) begin
        col_q <= to_op(in_i.vector_value);
      end
      if (!stall) begin
        ctl_q     <= ctl_d;
        // the memory read at this edge misses the write landing at this edge
        fwd_hit_q <= wr_en && ctl_d.valid && in_range && (addr_q == in_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      addr_q     <= in_addr;
      prod_q     <= prod_d;
      fwd_data_q <= {wr_sat, wr_acc};
    end
  end

  scmva_mem #(
    .DEPTH (Depth),
    .AW    (AW),
    .W     (MW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (in_addr),
    .rd_data_o (mem_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i ({wr_sat, wr_acc})
  );

  assign row_word = fwd_hit_q ? fwd_data_q : mem_rd;

  scmva_update #(
    .PW (PW)
  ) u_update (
    .ctl_i     (ctl_q),
    .acc_i     ($signed(row_word[ACC_BITS-1:0])),
    .sat_i     (row_word[ACC_BITS]),
    .prod_i    (prod_q),
    .wr_en_o   (wr_en_raw),
    .wr_acc_o  (wr_acc),
    .wr_sat_o  (wr_sat),
    .res_sum_o (res_sum),
    .res_ovf_o (res_ovf)
  );

  assign wr_en    = wr_en_raw && !stall;
  assign out_load = ctl_q.valid && ctl_q.read && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q <= res_sum;
      out_ovf_q <= res_ovf;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_sum    = out_sum_q;
  assign out_o.overflowed = out_ovf_q;

endmodule

`default_nettype wire

/* rtl/core/scmva_mem.sv */
// ----------------------------------------------------------------------------
// scmva_mem
// Row accumulator memory: one write and one registered read per cycle,
// with a valid bit per row so that rows never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scmva_mem import scmva_pkg::*; #(
  parameter int unsigned DEPTH = ROWS_DEF,
  parameter int unsigned AW    = 8,
  parameter int unsigned W     = ACC_BITS + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [W-1:0]  rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [W-1:0]  wr_data_i
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] row_valid_q;
  logic [W-1:0]     rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* rtl/core/scmva_update.sv */
// ----------------------------------------------------------------------------
// scmva_update
// Read-modify-write step: saturating add of a product into a row, or
// read-out and clear of a row.
// ----------------------------------------------------------------------------
`default_nettype none

module scmva_update import scmva_pkg::*; #(
  parameter int unsigned PW = 2 * VALUE_BITS_DEF
) (
  input  wire stage_ctl_t                ctl_i,
  input  wire logic signed [ACC_BITS-1:0] acc_i,
  input  wire logic                       sat_i,
  input  wire logic signed [PW-1:0]       prod_i,
  output logic                            wr_en_o,
  output logic signed [ACC_BITS-1:0]      wr_acc_o,
  output logic                            wr_sat_o,
  output logic signed [ACC_BITS-1:0]      res_sum_o,
  output logic                            res_ovf_o
);

  localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [ACC_BITS:0]   sum_w;
  logic                       ovf_w;
  logic signed [ACC_BITS-1:0] clamp_w;

  assign sum_w   = $signed({acc_i[ACC_BITS-1], acc_i}) + (ACC_BITS + 1)'(prod_i);
  assign ovf_w   = sum_w[ACC_BITS] != sum_w[ACC_BITS-1];
  // clamp toward the side the true sum lies on
  assign clamp_w = ovf_w ? (sum_w[ACC_BITS] ? AccMin : AccMax) : sum_w[ACC_BITS-1:0];

  always_comb begin
    wr_en_o   = ctl_i.valid && ctl_i.in_range && (ctl_i.entry || ctl_i.read);
    wr_acc_o  = '0;
    wr_sat_o  = 1'b0;
    res_sum_o = '0;
    res_ovf_o = 1'b0;
    if (ctl_i.entry) begin
      wr_acc_o = clamp_w;
      wr_sat_o = sat_i || ovf_w;
    end
    if (ctl_i.read && ctl_i.in_range) begin
      res_sum_o = acc_i;
      res_ovf_o = sat_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scmva_chk.sv */
// ----------------------------------------------------------------------------
// scmva_chk
// Port-level checks of the sparse column mat-vec accumulate unit, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_column_matvec_accumulate_unit_macros.svh"

module scmva_chk import scmva_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic [1:0]          in_cmd_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [ACC_BITS-1:0] out_row_sum_i,
  input wire logic                out_overflowed_i
);

  logic [1:0] pend_d, pend_q;
  logic       rd_acc, out_acc;

  assign rd_acc  = in_valid_i && in_ready_i && (in_cmd_i == CMD_READ);
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + {1'b0, rd_acc} - {1'b0, out_acc};

  // count read words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SCMVA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_sum_i) && $stable(out_overflowed_i), "result word changed while stalled")
  `SCMVA_ASSERT(a_no_extra_word, out_valid_i |-> pend_q != 2'd0, "result word without a read")
  `SCMVA_ASSERT(a_pend_bound, pend_q != 2'd3, "more reads in flight than stage and output hold")
  `SCMVA_ASSERT(a_stall_cause, !in_ready_i |-> out_valid_i, "input stalled with empty output")

endmodule

bind sparse_column_matvec_accumulate_unit scmva_chk u_scmva_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_cmd_i         (in_i.cmd),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_row_sum_i    (out_o.row_sum),
  .out_overflowed_i (out_o.overflowed)
);

`default_nettype wire
